@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the pulse charge finder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define WPCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on every clock edge outside reset.
`define WPCF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/core/wpcf_pkg.sv @@
// Shared types, constants and helpers of the pulse charge finder.
`timescale 1ns / 1ps

package wpcf_pkg;

  // Field widths.
  localparam int AdcW     = 12;
  localparam int ChanW    = 13;
  localparam int StartW   = 24;
  localparam int TimeW    = 25;
  localparam int SumW     = 31;
  localparam int HitW     = 16;
  localparam int KindW    = 2;
  localparam int PlaneW   = 13;
  localparam int LowLimW  = 16;

  // Stream widths.
  localparam int InDataW  = 56;
  localparam int InUserW  = 2;
  localparam int OutDataW = 64;
  localparam int OutUserW = 3;

  // Configuration port.
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgBaseline  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgThreshold = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPlane     = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgLowLimit  = 2'd3;

  // Register reset values.
  localparam logic [AdcW-1:0]    BaselineRst  = 12'd400;
  localparam logic [AdcW-1:0]    ThresholdRst = 12'd3;
  localparam logic [PlaneW-1:0]  PlaneRst     = 13'd1500;
  localparam logic [LowLimW-1:0] LowLimitRst  = 16'd100;

  // Result kinds.
  localparam logic [KindW-1:0] KindPulse = 2'd0;
  localparam logic [KindW-1:0] KindWire  = 2'd1;
  localparam logic [KindW-1:0] KindEvent = 2'd2;

  // Default waveform length limit.
  localparam int MaxWaveSamplesDef = 4096;

  // Depth of the queue between front and back.
  localparam int QueueDepth = 2;
  localparam int QPtrW      = 1;

  typedef struct packed {
    logic [AdcW-1:0]    baseline;
    logic [AdcW-1:0]    pulse_threshold;
    logic [PlaneW-1:0]  plane_limit;
    logic [LowLimW-1:0] low_charge_limit;
  } cfg_t;

  // A classified item as it travels from front to back.
  typedef struct packed {
    logic              command;
    logic              first;
    logic              last;
    logic              above;
    logic [AdcW-1:0]   excess;
    logic              plane_hit;
    logic [TimeW-1:0]  t;
    logic [ChanW-1:0]  channel;
  } cls_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [SumW-1:0]  charge;
    logic             low_charge;
    logic [ChanW-1:0] wire_res;
    logic [HitW-1:0]  hit_count;
    logic             last;
  } result_t;

  // Saturating add of a sample excess to a charge sum.
  function automatic logic [SumW-1:0] sat_add(logic [SumW-1:0] a, logic [AdcW-1:0] e);
    logic [SumW:0] s;
    s = {1'b0, a} + (SumW + 1)'(e);
    return s[SumW] ? '1 : s[SumW-1:0];
  endfunction

endpackage

@@ rtl/core/wpcf_front.sv @@
// Front part: accepts input items, tracks the sample index and classifies samples.
`timescale 1ns / 1ps

module wpcf_front import wpcf_pkg::*; #(
  parameter int MAX_WAVE_SAMPLES = MaxWaveSamplesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic              command_i,
  input  logic [AdcW-1:0]   adc_i,
  input  logic [ChanW-1:0]  channel_i,
  input  logic [StartW-1:0] start_time_i,
  input  logic              first_i,
  input  logic              last_i,
  output logic              push_o,
  output cls_t              cls_o,
  input  logic              q_ready_i
);

  localparam int IdxW = (MAX_WAVE_SAMPLES > 1) ? $clog2(MAX_WAVE_SAMPLES) : 1;
  localparam logic [IdxW-1:0] IdxMax = IdxW'(MAX_WAVE_SAMPLES - 1);

  logic [IdxW-1:0] idx_q, idx_d, idx_cur;
  logic [AdcW:0]   diff;

  assign s_ready_o = q_ready_i;
  assign push_o    = s_valid_i && q_ready_i;

  // Sample index restarts on a first sample and saturates on long waveforms.
  assign idx_cur = first_i ? '0 : idx_q;

  always_comb begin
    idx_d = idx_q;
    if (push_o) begin
      if (command_i) begin
        idx_d = '0;
      end else if (idx_cur < IdxMax) begin
        idx_d = idx_cur + IdxW'(1);
      end else begin
        idx_d = idx_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // Excess over baseline; a negative excess never reaches the threshold.
  assign diff = {1'b0, adc_i} - {1'b0, cfg_i.baseline};

  always_comb begin
    cls_o.command   = command_i;
    cls_o.first     = first_i;
    cls_o.last      = last_i;
    cls_o.excess    = diff[AdcW-1:0];
    cls_o.above     = !diff[AdcW] && (diff[AdcW-1:0] >= cfg_i.pulse_threshold);
    cls_o.plane_hit = {1'b0, adc_i} < cfg_i.plane_limit;
    cls_o.t         = TimeW'(start_time_i) + TimeW'(idx_cur);
    cls_o.channel   = channel_i;
  end

endmodule

@@ rtl/core/wpcf_queue.sv @@
// Short queue of classified items between the front and back parts.
`timescale 1ns / 1ps

module wpcf_queue import wpcf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cls_t data_i,
  output logic ready_o,
  output logic valid_o,
  output cls_t data_o,
  input  logic pop_i
);

  cls_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o = (count_q != (QPtrW + 1)'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (QPtrW + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (QPtrW + 1)'(1);
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      count_q <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/core/wpcf_back.sv @@
// Back part: pulse, wire and event state, and the result output stage.
`timescale 1ns / 1ps

module wpcf_back import wpcf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    item_valid_i,
  input  cls_t    item_i,
  output logic    item_ready_o,
  output logic    res_valid_o,
  output result_t res_o,
  input  logic    res_ready_i
);

  logic [TimeW-1:0] ct_q, ct_d;
  logic             in_pulse_q, in_pulse_d;
  logic [SumW-1:0]  pulse_sum_q, pulse_sum_d;
  logic [SumW-1:0]  wire_sum_q, wire_sum_d;
  logic [SumW-1:0]  event_sum_q, event_sum_d;
  logic [HitW-1:0]  hits_q, hits_d;
  logic             plane_ok_q, plane_ok_d;
  logic [ChanW-1:0] prev_ch_q, prev_ch_d;
  logic             seen_q, seen_d;

  result_t out_q, out_d, pend_q, pend_d;
  logic    out_valid_q, out_valid_d, pend_valid_q, pend_valid_d;

  logic    consume;
  logic    pulse_emit, wire_emit, event_emit;
  result_t pulse_res, wire_res, event_res;

  // An item is taken only when both of its possible results have room.
  assign item_ready_o = !pend_valid_q && (!out_valid_q || res_ready_i);
  assign consume      = item_valid_i && item_ready_o;

  // State update for one item.
  always_comb begin
    ct_d        = ct_q;
    in_pulse_d  = in_pulse_q;
    pulse_sum_d = pulse_sum_q;
    wire_sum_d  = wire_sum_q;
    event_sum_d = event_sum_q;
    hits_d      = hits_q;
    plane_ok_d  = plane_ok_q;
    prev_ch_d   = prev_ch_q;
    seen_d      = seen_q;
    pulse_emit  = 1'b0;
    wire_emit   = 1'b0;
    event_emit  = 1'b0;

    pulse_res            = '0;
    pulse_res.kind       = KindPulse;
    pulse_res.charge     = pulse_sum_q;
    pulse_res.low_charge = pulse_sum_q < SumW'(cfg_i.low_charge_limit);

    event_res            = '0;
    event_res.kind       = KindEvent;
    event_res.charge     = event_sum_q;
    event_res.hit_count  = hits_q;
    event_res.last       = 1'b1;

    wire_res          = '0;
    wire_res.kind     = KindWire;
    wire_res.last     = 1'b1;

    if (item_i.command) begin
      // End of event: report and clear everything.
      event_emit  = 1'b1;
      ct_d        = '0;
      in_pulse_d  = 1'b0;
      pulse_sum_d = '0;
      wire_sum_d  = '0;
      event_sum_d = '0;
      hits_d      = '0;
      plane_ok_d  = 1'b0;
      prev_ch_d   = '0;
      seen_d      = 1'b0;
    end else begin
      // Waveform start: a new channel forgets the counted time.
      if (item_i.first) begin
        if (seen_q && (item_i.channel != prev_ch_q)) begin
          ct_d = '0;
        end
        prev_ch_d  = item_i.channel;
        seen_d     = 1'b1;
        in_pulse_d = 1'b0;
        plane_ok_d = item_i.plane_hit;
      end
      if (plane_ok_d) begin
        if (item_i.above) begin
          if (item_i.t > ct_d) begin
            ct_d        = item_i.t;
            in_pulse_d  = 1'b1;
            pulse_sum_d = sat_add(pulse_sum_q, item_i.excess);
            wire_sum_d  = sat_add(wire_sum_q, item_i.excess);
            event_sum_d = sat_add(event_sum_q, item_i.excess);
          end
        end else begin
          if (in_pulse_d) begin
            pulse_emit  = 1'b1;
            pulse_sum_d = '0;
            if (hits_q != '1) begin
              hits_d = hits_q + HitW'(1);
            end
          end
          in_pulse_d = 1'b0;
        end
        // The wire charge includes the last sample's own excess.
        if (item_i.last) begin
          wire_emit       = 1'b1;
          wire_res.charge = wire_sum_d;
          wire_sum_d      = '0;
        end
      end
      if (item_i.last) begin
        in_pulse_d = 1'b0;
      end
    end

    pulse_res.wire_res = prev_ch_d;
    pulse_res.last     = !wire_emit;

    wire_res.wire_res = prev_ch_d;
  end

  // Output register with one pending slot for a second result.
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    if (out_valid_q && res_ready_i) begin
      out_valid_d  = pend_valid_q;
      out_d        = pend_q;
      pend_valid_d = 1'b0;
    end
    if (consume) begin
      if (event_emit) begin
        out_d       = event_res;
        out_valid_d = 1'b1;
      end else if (pulse_emit) begin
        out_d       = pulse_res;
        out_valid_d = 1'b1;
        if (wire_emit) begin
          pend_d       = wire_res;
          pend_valid_d = 1'b1;
        end
      end else if (wire_emit) begin
        out_d       = wire_res;
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ct_q         <= '0;
      in_pulse_q   <= 1'b0;
      pulse_sum_q  <= '0;
      wire_sum_q   <= '0;
      event_sum_q  <= '0;
      hits_q       <= '0;
      plane_ok_q   <= 1'b0;
      prev_ch_q    <= '0;
      seen_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (consume) begin
        ct_q        <= ct_d;
        in_pulse_q  <= in_pulse_d;
        pulse_sum_q <= pulse_sum_d;
        wire_sum_q  <= wire_sum_d;
        event_sum_q <= event_sum_d;
        hits_q      <= hits_d;
        plane_ok_q  <= plane_ok_d;
        prev_ch_q   <= prev_ch_d;
        seen_q      <= seen_d;
      end
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

@@ rtl/core/waveform_pulse_charge_finder.sv @@
// Top level of the pulse charge finder: configuration registers and stream ports.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Finds threshold pulses in detector waveforms and sums their charge.
// Input stream: one item per waveform sample or one end-of-event command.
// A waveform is marked by first_sample in tuser and by tlast on its last sample.
// Output stream: pulse charge, wire charge and event summary results; tlast
// marks the last result caused by one input item.
// Throughput: one input item per clock while the output is taken and no result
// waits in the pending slot; an item that closes a pulse on a waveform's last
// sample gives two results; they leave in turn from the output and pending slots.
// Path: an accepted item is written into the queue; the back part then takes it
// and registers its result in the output register, which drives the receiver.
// The per-item state update in the back part is the loop that sets the rate.
// Reset clears all pulse, wire and event sums and loads the register defaults.
// When the receiver stalls, the output holds its result, the back part stops
// taking items, the two-entry queue fills and then s_axis_tready drops.
// Configuration writes take effect on the next edge; write only while idle.

module waveform_pulse_charge_finder import wpcf_pkg::*; #(
  parameter int MAX_WAVE_SAMPLES = MaxWaveSamplesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // adc, channel, start_time, zero pad
  input  logic [InUserW-1:0]  s_axis_tuser,   // command, first_sample
  input  logic                s_axis_tlast,   // last_sample
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // charge, wire_res, hit_count, zero pad
  output logic [OutUserW-1:0] m_axis_tuser,   // kind, low_charge
  output logic                m_axis_tlast    // last
);

  cfg_t    cfg_q, cfg_d;
  logic    push, q_ready, q_valid, q_pop;
  cls_t    cls_in, cls_out;
  logic    res_valid;
  result_t res;

  // Configuration registers.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBaseline:  cfg_d.baseline         = cfg_data_i[AdcW-1:0];
        CfgThreshold: cfg_d.pulse_threshold  = cfg_data_i[AdcW-1:0];
        CfgPlane:     cfg_d.plane_limit      = cfg_data_i[PlaneW-1:0];
        CfgLowLimit:  cfg_d.low_charge_limit = cfg_data_i[LowLimW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.baseline         <= BaselineRst;
      cfg_q.pulse_threshold  <= ThresholdRst;
      cfg_q.plane_limit      <= PlaneRst;
      cfg_q.low_charge_limit <= LowLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  wpcf_front #(
    .MAX_WAVE_SAMPLES(MAX_WAVE_SAMPLES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .command_i   (s_axis_tuser[0]),
    .adc_i       (s_axis_tdata[11:0]),
    .channel_i   (s_axis_tdata[24:12]),
    .start_time_i(s_axis_tdata[48:25]),
    .first_i     (s_axis_tuser[1]),
    .last_i      (s_axis_tlast),
    .push_o      (push),
    .cls_o       (cls_in),
    .q_ready_i   (q_ready)
  );

  wpcf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cls_in),
    .ready_o(q_ready),
    .valid_o(q_valid),
    .data_o (cls_out),
    .pop_i  (q_pop)
  );

  wpcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_valid_i(q_valid),
    .item_i      (cls_out),
    .item_ready_o(q_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (m_axis_tready)
  );

  // Output packing.
  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {(OutDataW - SumW - ChanW - HitW)'(0),
                          res.hit_count, res.wire_res, res.charge};
  assign m_axis_tuser  = {res.low_charge, res.kind};
  assign m_axis_tlast  = res.last;

  // An event summary is always the only, and so the last, result of its item.
  `WPCF_ASSERT_IMPL(a_event_is_last, res_valid && (res.kind == KindEvent), res.last, "event summary without last")
  // Only pulse results may carry the low-charge flag.
  `WPCF_ASSERT_IMPL(a_low_on_pulse, res_valid && res.low_charge, res.kind == KindPulse, "low charge flag on non-pulse result")
  // Hit counts appear only in event summaries.
  `WPCF_ASSERT_IMPL(a_hits_on_event, res_valid && (res.kind != KindEvent), res.hit_count == '0, "hit count on non-event result")

endmodule
